// ----- rtl/core/mafp_pkg.sv -----
`default_nettype none
package mafp_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int NSETS         = 6;
    localparam int SET_BITS      = 3;
    localparam int RAM_DEPTH     = NSETS * TABLE_ENTRIES;
    localparam int RAM_AW        = SET_BITS + IDX_BITS;
    localparam int KEY_BITS      = 64;
    localparam int COUNT_BITS    = 48;
    localparam int OUT_BITS      = 48;
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;
    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    localparam logic [SET_BITS-1:0] SET_SLD = 3'd0;
    localparam logic [SET_BITS-1:0] SET_VL  = 3'd2;
    localparam logic [SET_BITS-1:0] SET_ML  = 3'd4;

    localparam logic [3:0] REC_TOTAL_BASE  = 4'd4;
    localparam logic [3:0] REC_UNIQUE_BASE = 4'd10;
    localparam logic [3:0] REC_LAST        = 4'd11;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [3:0] {
        CMD_SLD    = 4'd0,
        CMD_SST    = 4'd1,
        CMD_MLD    = 4'd2,
        CMD_MST    = 4'd3,
        CMD_VBEGIN = 4'd4,
        CMD_VACC   = 4'd5,
        CMD_VEND   = 4'd6,
        CMD_VFAULT = 4'd7,
        CMD_BEGIN  = 4'd8,
        CMD_END    = 4'd9,
        CMD_ABORT  = 4'd10
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        vkind;
        logic [15:0] bytes;
        logic [63:0] addr;
        logic [63:0] pc;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } queue_head_t;

    function automatic count_t sat_add(input count_t a, input count_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[COUNT_BITS])
            return '1;
        return s[COUNT_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] out_clamp(input count_t v);
        logic [63:0] w;
        w = 64'(v);
        if (w > 64'(OUT_MAX))
            return OUT_MAX;
        return w[OUT_BITS-1:0];
    endfunction

    function automatic logic [SET_BITS-1:0] report_set(input logic [2:0] n);
        case (n)
            3'd0:    return 3'd2;
            3'd1:    return 3'd3;
            3'd2:    return 3'd4;
            3'd3:    return 3'd5;
            3'd4:    return 3'd0;
            default: return 3'd1;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mafp_item_if.sv -----
`default_nettype none
interface mafp_item_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic        vector_kind;
    logic [15:0] access_bytes;
    logic [63:0] access_address;
    logic [63:0] instr_pc;

    modport source (output valid, command, vector_kind, access_bytes, access_address,
                    instr_pc, input ready);
    modport sink (input valid, command, vector_kind, access_bytes, access_address,
                  instr_pc, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mafp_result_if.sv -----
`default_nettype none
interface mafp_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  record_kind;
    logic [47:0] byte_count;
    logic [63:0] record_pc;
    logic [63:0] record_address;
    logic        partial_flag;
    logic        table_overflow;
    logic        last_record;

    modport source (output valid, record_kind, byte_count, record_pc, record_address,
                    partial_flag, table_overflow, last_record, input ready);
    modport sink (input valid, record_kind, byte_count, record_pc, record_address,
                  partial_flag, table_overflow, last_record, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/memory_access_footprint_profiler_top.sv -----
// channel  | dir | beat
// item     | in  | one command: access, vector control, begin, end or abort
// result   | out | one record: event or total, last_record marks the last
//
// An access that touches a table runs two 64-bit multiplies (three 32x32
// passes each), then a linear probe. End takes 12 result beats. Begin, end
// and abort, and reset, run a clear pass over all 6144 slots (one slot a
// cycle) during which no command leaves the queue. A two-beat queue parts
// intake from execution; a pending result holds the next command and the
// totals, and stalls intake only once the queue is full.
`default_nettype none
module memory_access_footprint_profiler_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mafp_item_if.sink     item,
    mafp_result_if.source result
);
    mafp_pkg::queue_head_t head;
    logic                  pop;

    mafp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .pop   (pop),
        .head  (head)
    );

    mafp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );
endmodule
`default_nettype wire

// ----- rtl/core/mafp_ram.sv -----
`default_nettype none
module mafp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/mafp_front.sv -----
`default_nettype none
module mafp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    mafp_item_if.sink                 item,
    input  wire logic                 pop,
    output mafp_pkg::queue_head_t     head
);
    mafp_pkg::op_t q_mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    logic          known;

    assign item.ready = (count_reg != 2'd2);
    assign known      = (item.command <= mafp_pkg::CMD_ABORT);
    assign push       = item.valid && item.ready && known;
    assign head.valid = (count_reg != 2'd0);
    assign head.op    = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{cmd:   mafp_pkg::cmd_t'(item.command),
                                      vkind: item.vector_kind,
                                      bytes: item.access_bytes,
                                      addr:  item.access_address,
                                      pc:    item.instr_pc};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |=> count_reg != 2'd3) else $error("queue overrun");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1) else $error("lost beat");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/mafp_back.sv -----
`default_nettype none
module mafp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mafp_pkg::queue_head_t head,
    output logic                      pop,
    mafp_result_if.source             result
);
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EMIT,
        S_MUL,
        S_PROBE_RD,
        S_PROBE_CHK
    } state_t;

    state_t                          state_reg;
    logic                            trace_on_reg;
    mafp_pkg::count_t                byte_tot_reg [mafp_pkg::NSETS];
    mafp_pkg::count_t                uniq_tot_reg [mafp_pkg::NSETS];
    logic [mafp_pkg::NSETS-1:0]      ovf_reg;
    logic                            ev_active_reg;
    logic                            ev_kind_reg;
    logic [63:0]                     ev_pc_reg;
    mafp_pkg::count_t                ev_bytes_reg;
    logic [63:0]                     ev_addr_reg;
    logic [mafp_pkg::SET_BITS-1:0]   ins_set_reg;
    logic [63:0]                     ins_key_reg;
    mafp_pkg::count_t                ins_bytes_reg;
    logic [63:0]                     mul_a_reg;
    logic [63:0]                     acc_reg;
    logic [1:0]                      part_reg;
    logic                            phase_reg;
    logic [mafp_pkg::IDX_BITS-1:0]   idx_reg;
    logic [mafp_pkg::IDX_BITS:0]     probe_cnt_reg;
    logic [mafp_pkg::RAM_AW-1:0]     clr_cnt_reg;
    logic [3:0]                      emit_cnt_reg;
    logic                            out_valid_reg;
    logic [3:0]                      out_kind_reg;
    logic [47:0]                     out_bytes_reg;
    logic [63:0]                     out_pc_reg;
    logic [63:0]                     out_addr_reg;
    logic                            out_partial_reg;
    logic                            out_ovf_reg;
    logic                            out_last_reg;

    logic [63:0]                     mul_b;
    logic [31:0]                     mul_x;
    logic [31:0]                     mul_y;
    logic [63:0]                     prod;
    logic [63:0]                     acc_sum;
    logic [63:0]                     mixed;
    logic [63:0]                     key_pre;
    logic                            ram_wr_en;
    logic [mafp_pkg::RAM_AW-1:0]     ram_wr_addr;
    logic [mafp_pkg::KEY_BITS:0]     ram_wr_data;
    logic                            ram_rd_en;
    logic [mafp_pkg::KEY_BITS:0]     ram_rd_data;
    logic                            slot_free;
    logic                            slot_hit;
    logic                            out_free;
    logic [mafp_pkg::SET_BITS-1:0]   emit_set;
    logic [mafp_pkg::SET_BITS-1:0]   op_set;
    mafp_pkg::op_t                   op;

    assign op       = head.op;
    assign out_free = !out_valid_reg || result.ready;
    assign pop      = (state_reg == S_IDLE) && head.valid && !out_valid_reg;
    assign op_set   = (op.cmd == mafp_pkg::CMD_SLD || op.cmd == mafp_pkg::CMD_SST)
                      ? op.cmd[mafp_pkg::SET_BITS-1:0]
                      : op.cmd[mafp_pkg::SET_BITS-1:0] + 3'd2;
    assign key_pre  = (op.cmd == mafp_pkg::CMD_SLD || op.cmd == mafp_pkg::CMD_SST ||
                       op.cmd == mafp_pkg::CMD_MLD || op.cmd == mafp_pkg::CMD_MST)
                      ? op.addr : ev_addr_reg;

    assign mul_b = phase_reg ? mafp_pkg::MIX_C2 : mafp_pkg::MIX_C1;
    assign mul_x = (part_reg == 2'd2) ? mul_a_reg[63:32] : mul_a_reg[31:0];
    assign mul_y = (part_reg == 2'd1) ? mul_b[63:32] : mul_b[31:0];
    assign prod  = 64'(mul_x) * 64'(mul_y);
    assign acc_sum = (part_reg == 2'd0) ? prod : acc_reg + {prod[31:0], 32'd0};
    assign mixed   = acc_sum ^ (acc_sum >> 31);

    assign emit_set = (emit_cnt_reg < 4'd6) ? mafp_pkg::report_set(emit_cnt_reg[2:0])
                      : mafp_pkg::report_set(3'(emit_cnt_reg - 4'd6));

    assign slot_free = !ram_rd_data[mafp_pkg::KEY_BITS];
    assign slot_hit  = ram_rd_data[mafp_pkg::KEY_BITS-1:0] == ins_key_reg;

    assign ram_rd_en   = (state_reg == S_PROBE_RD);
    assign ram_wr_en   = (state_reg == S_CLEAR) || (state_reg == S_PROBE_CHK && slot_free);
    assign ram_wr_addr = (state_reg == S_CLEAR) ? clr_cnt_reg : {ins_set_reg, idx_reg};
    assign ram_wr_data = (state_reg == S_CLEAR) ? '0 : {1'b1, ins_key_reg};

    mafp_ram #(
        .WIDTH (mafp_pkg::KEY_BITS + 1),
        .DEPTH (mafp_pkg::RAM_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr ({ins_set_reg, idx_reg}),
        .rd_data (ram_rd_data)
    );

    assign result.valid          = out_valid_reg;
    assign result.record_kind    = out_kind_reg;
    assign result.byte_count     = out_bytes_reg;
    assign result.record_pc      = out_pc_reg;
    assign result.record_address = out_addr_reg;
    assign result.partial_flag   = out_partial_reg;
    assign result.table_overflow = out_ovf_reg;
    assign result.last_record    = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            trace_on_reg  <= 1'b0;
            byte_tot_reg  <= '{default: '0};
            uniq_tot_reg  <= '{default: '0};
            ovf_reg       <= '0;
            ev_active_reg <= 1'b0;
            ev_kind_reg   <= 1'b0;
            ev_pc_reg     <= '0;
            ev_bytes_reg  <= '0;
            ev_addr_reg   <= '0;
            clr_cnt_reg   <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            part_reg      <= '0;
            phase_reg     <= 1'b0;
            probe_cnt_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == mafp_pkg::RAM_AW'(mafp_pkg::RAM_DEPTH - 1))
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pop)
                    begin
                        case (op.cmd)
                            mafp_pkg::CMD_SLD, mafp_pkg::CMD_SST,
                            mafp_pkg::CMD_MLD, mafp_pkg::CMD_MST:
                            begin
                                if (trace_on_reg)
                                begin
                                    byte_tot_reg[op_set] <= mafp_pkg::sat_add(
                                        byte_tot_reg[op_set], mafp_pkg::count_t'(op.bytes));
                                    ins_set_reg   <= op_set;
                                    ins_key_reg   <= key_pre;
                                    ins_bytes_reg <= mafp_pkg::count_t'(op.bytes);
                                    mul_a_reg     <= key_pre ^ (key_pre >> 30);
                                    part_reg      <= 2'd0;
                                    phase_reg     <= 1'b0;
                                    state_reg     <= S_MUL;
                                    if (op.cmd == mafp_pkg::CMD_MLD ||
                                        op.cmd == mafp_pkg::CMD_MST)
                                    begin
                                        out_valid_reg   <= 1'b1;
                                        out_kind_reg    <= op.cmd;
                                        out_bytes_reg   <= 48'(op.bytes);
                                        out_pc_reg      <= op.pc;
                                        out_addr_reg    <= op.addr;
                                        out_partial_reg <= 1'b0;
                                        out_ovf_reg     <= 1'b0;
                                        out_last_reg    <= 1'b1;
                                    end
                                end
                            end
                            mafp_pkg::CMD_VBEGIN, mafp_pkg::CMD_VEND, mafp_pkg::CMD_VFAULT:
                            begin
                                if (trace_on_reg && ev_active_reg)
                                begin
                                    out_valid_reg   <= 1'b1;
                                    out_kind_reg    <= {3'd0, ev_kind_reg};
                                    out_bytes_reg   <= mafp_pkg::out_clamp(ev_bytes_reg);
                                    out_pc_reg      <= ev_pc_reg;
                                    out_addr_reg    <= ev_addr_reg;
                                    out_partial_reg <= (op.cmd != mafp_pkg::CMD_VEND);
                                    out_ovf_reg     <= 1'b0;
                                    out_last_reg    <= 1'b1;
                                    if (ev_bytes_reg != '0)
                                    begin
                                        ins_set_reg   <= mafp_pkg::SET_VL + {2'd0, ev_kind_reg};
                                        ins_key_reg   <= key_pre;
                                        ins_bytes_reg <= ev_bytes_reg;
                                        mul_a_reg     <= key_pre ^ (key_pre >> 30);
                                        part_reg      <= 2'd0;
                                        phase_reg     <= 1'b0;
                                        state_reg     <= S_MUL;
                                    end
                                end
                                if (trace_on_reg)
                                begin
                                    ev_active_reg <= (op.cmd == mafp_pkg::CMD_VBEGIN);
                                    ev_kind_reg   <= (op.cmd == mafp_pkg::CMD_VBEGIN)
                                                     ? op.vkind : 1'b0;
                                    ev_pc_reg     <= (op.cmd == mafp_pkg::CMD_VBEGIN)
                                                     ? op.pc : '0;
                                    ev_bytes_reg  <= '0;
                                    ev_addr_reg   <= '0;
                                end
                            end
                            mafp_pkg::CMD_VACC:
                            begin
                                if (trace_on_reg && ev_active_reg)
                                begin
                                    if (ev_bytes_reg == '0 && op.bytes != '0)
                                    begin
                                        ev_addr_reg <= op.addr;
                                    end
                                    ev_bytes_reg <= mafp_pkg::sat_add(ev_bytes_reg,
                                        mafp_pkg::count_t'(op.bytes));
                                    byte_tot_reg[mafp_pkg::SET_VL + {2'd0, ev_kind_reg}] <=
                                        mafp_pkg::sat_add(
                                            byte_tot_reg[mafp_pkg::SET_VL + {2'd0, ev_kind_reg}],
                                            mafp_pkg::count_t'(op.bytes));
                                end
                            end
                            mafp_pkg::CMD_BEGIN, mafp_pkg::CMD_ABORT:
                            begin
                                trace_on_reg  <= (op.cmd == mafp_pkg::CMD_BEGIN);
                                byte_tot_reg  <= '{default: '0};
                                uniq_tot_reg  <= '{default: '0};
                                ovf_reg       <= '0;
                                ev_active_reg <= 1'b0;
                                ev_kind_reg   <= 1'b0;
                                ev_pc_reg     <= '0;
                                ev_bytes_reg  <= '0;
                                ev_addr_reg   <= '0;
                                state_reg     <= S_CLEAR;
                            end
                            mafp_pkg::CMD_END:
                            begin
                                if (trace_on_reg)
                                begin
                                    emit_cnt_reg <= '0;
                                    state_reg    <= S_EMIT;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_kind_reg    <= mafp_pkg::REC_TOTAL_BASE + emit_cnt_reg;
                        out_pc_reg      <= '0;
                        out_addr_reg    <= '0;
                        out_partial_reg <= 1'b0;
                        out_last_reg    <= (emit_cnt_reg == mafp_pkg::REC_LAST);
                        if (emit_cnt_reg < 4'd6)
                        begin
                            out_bytes_reg <= mafp_pkg::out_clamp(byte_tot_reg[emit_set]);
                            out_ovf_reg   <= 1'b0;
                        end
                        else
                        begin
                            out_bytes_reg <= mafp_pkg::out_clamp(uniq_tot_reg[emit_set]);
                            out_ovf_reg   <= ovf_reg[emit_set];
                        end
                        emit_cnt_reg <= emit_cnt_reg + 4'd1;
                        if (emit_cnt_reg == mafp_pkg::REC_LAST)
                        begin
                            trace_on_reg  <= 1'b0;
                            byte_tot_reg  <= '{default: '0};
                            uniq_tot_reg  <= '{default: '0};
                            ovf_reg       <= '0;
                            ev_active_reg <= 1'b0;
                            ev_kind_reg   <= 1'b0;
                            ev_pc_reg     <= '0;
                            ev_bytes_reg  <= '0;
                            ev_addr_reg   <= '0;
                            state_reg     <= S_CLEAR;
                        end
                    end
                end
                S_MUL:
                begin
                    acc_reg  <= acc_sum;
                    part_reg <= part_reg + 2'd1;
                    if (part_reg == 2'd2)
                    begin
                        part_reg <= 2'd0;
                        if (!phase_reg)
                        begin
                            mul_a_reg <= acc_sum ^ (acc_sum >> 27);
                            phase_reg <= 1'b1;
                        end
                        else
                        begin
                            idx_reg       <= mixed[mafp_pkg::IDX_BITS-1:0];
                            probe_cnt_reg <= '0;
                            state_reg     <= S_PROBE_RD;
                        end
                    end
                end
                S_PROBE_RD:
                begin
                    state_reg <= S_PROBE_CHK;
                end
                S_PROBE_CHK:
                begin
                    if (slot_free)
                    begin
                        uniq_tot_reg[ins_set_reg] <= mafp_pkg::sat_add(
                            uniq_tot_reg[ins_set_reg], ins_bytes_reg);
                        state_reg <= S_IDLE;
                    end
                    else if (slot_hit)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (probe_cnt_reg ==
                             (mafp_pkg::IDX_BITS+1)'(mafp_pkg::TABLE_ENTRIES - 1))
                    begin
                        ovf_reg[ins_set_reg] <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg       <= idx_reg + 1'b1;
                        probe_cnt_reg <= probe_cnt_reg + 1'b1;
                        state_reg     <= S_PROBE_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_pop_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !out_valid_reg) else $error("pop with result pending");
    a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE_CHK |-> $past(state_reg) == S_PROBE_RD)
        else $error("slot check without read");
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE_RD |->
        probe_cnt_reg < (mafp_pkg::IDX_BITS+1)'(mafp_pkg::TABLE_ENTRIES))
        else $error("probe past table size");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && !out_free |=> $stable(emit_cnt_reg))
        else $error("total skipped");
`endif
endmodule
`default_nettype wire

// ----- verif/memory_access_footprint_profiler_top_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module memory_access_footprint_profiler_top_tb;

    localparam int SLOTS       = mafp_pkg::TABLE_ENTRIES;
    localparam int QUIET_WAIT  = 7000;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int CALM_ITEMS  = 50;

    typedef struct packed {
        logic [3:0]  kind;
        logic [47:0] bytes;
        logic [63:0] pc;
        logic [63:0] addr;
        logic        partial;
        logic        ovf;
        logic        last;
    } record_t;

    localparam logic [2:0] REPORT_ORDER [6] = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd1};

    logic clk;
    logic rst_n;

    mafp_item_if   item ();
    mafp_result_if result ();

    memory_access_footprint_profiler_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    mafp_pkg::op_t pending_ops[$];
    record_t       expected_records[$];
    logic [63:0]   addr_pool[16];

    int  fail_count;
    int  cycle_count;
    bit  beat_taken;
    int  send_idle;
    int  recv_idle;

    bit          tracing;
    logic [47:0] byte_total[6];
    logic [47:0] unique_total[6];
    bit          set_overflow[6];
    bit          slot_used[6][SLOTS];
    logic [63:0] slot_addr[6][SLOTS];
    bit          vec_open;
    logic        vec_kind;
    logic [63:0] vec_pc;
    logic [47:0] vec_bytes;
    logic [63:0] vec_addr;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [47:0] add_clamped(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    function automatic logic [mafp_pkg::IDX_BITS-1:0] home_slot(logic [63:0] a);
        logic [63:0] x;
        x = a;
        x = x ^ (x >> 30);
        x = x * mafp_pkg::MIX_C1;
        x = x ^ (x >> 27);
        x = x * mafp_pkg::MIX_C2;
        x = x ^ (x >> 31);
        return x[mafp_pkg::IDX_BITS-1:0];
    endfunction

    function automatic void add_unique(int s, logic [63:0] a, logic [47:0] b);
        logic [mafp_pkg::IDX_BITS-1:0] idx;
        idx = home_slot(a);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!slot_used[s][idx])
            begin
                slot_used[s][idx] = 1'b1;
                slot_addr[s][idx] = a;
                unique_total[s] = add_clamped(unique_total[s], b);
                return;
            end
            if (slot_addr[s][idx] == a)
                return;
            idx = idx + 1'b1;
        end
        set_overflow[s] = 1'b1;
    endfunction

    function automatic void clear_profile();
        for (int s = 0; s < 6; s++)
        begin
            byte_total[s]   = '0;
            unique_total[s] = '0;
            set_overflow[s] = 1'b0;
            for (int i = 0; i < SLOTS; i++)
                slot_used[s][i] = 1'b0;
        end
        vec_open  = 1'b0;
        vec_kind  = 1'b0;
        vec_pc    = '0;
        vec_bytes = '0;
        vec_addr  = '0;
    endfunction

    function automatic record_t make_record(logic [3:0] k, logic [47:0] b, logic [63:0] p,
                                            logic [63:0] a, logic part, logic ov);
        record_t r;
        r.kind    = k;
        r.bytes   = b;
        r.pc      = p;
        r.addr    = a;
        r.partial = part;
        r.ovf     = ov;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic void close_vector_event(ref record_t outs[$], input logic part);
        if (!vec_open)
            return;
        if (vec_bytes != 0)
            add_unique(2 + int'(vec_kind), vec_addr, vec_bytes);
        outs.push_back(make_record({3'd0, vec_kind}, vec_bytes, vec_pc, vec_addr, part, 1'b0));
        vec_open  = 1'b0;
        vec_kind  = 1'b0;
        vec_pc    = '0;
        vec_bytes = '0;
        vec_addr  = '0;
    endfunction

    function automatic void predict_records(mafp_pkg::op_t op);
        record_t outs[$];
        int s;
        case (op.cmd)
            mafp_pkg::CMD_SLD, mafp_pkg::CMD_SST:
                if (tracing)
                begin
                    s = int'(op.cmd);
                    byte_total[s] = add_clamped(byte_total[s], 48'(op.bytes));
                    add_unique(s, op.addr, 48'(op.bytes));
                end
            mafp_pkg::CMD_MLD, mafp_pkg::CMD_MST:
                if (tracing)
                begin
                    s = int'(op.cmd) + 2;
                    byte_total[s] = add_clamped(byte_total[s], 48'(op.bytes));
                    add_unique(s, op.addr, 48'(op.bytes));
                    outs.push_back(make_record(op.cmd, 48'(op.bytes), op.pc, op.addr,
                                               1'b0, 1'b0));
                end
            mafp_pkg::CMD_VBEGIN:
                if (tracing)
                begin
                    close_vector_event(outs, 1'b1);
                    vec_open = 1'b1;
                    vec_kind = op.vkind;
                    vec_pc   = op.pc;
                end
            mafp_pkg::CMD_VACC:
                if (tracing && vec_open)
                begin
                    if (vec_bytes == 0 && op.bytes != 0)
                        vec_addr = op.addr;
                    vec_bytes = add_clamped(vec_bytes, 48'(op.bytes));
                    s = 2 + int'(vec_kind);
                    byte_total[s] = add_clamped(byte_total[s], 48'(op.bytes));
                end
            mafp_pkg::CMD_VEND, mafp_pkg::CMD_VFAULT:
                if (tracing)
                    close_vector_event(outs, op.cmd == mafp_pkg::CMD_VFAULT);
            mafp_pkg::CMD_BEGIN:
            begin
                clear_profile();
                tracing = 1'b1;
            end
            mafp_pkg::CMD_END:
                if (tracing)
                begin
                    for (int n = 0; n < 6; n++)
                        outs.push_back(make_record(mafp_pkg::REC_TOTAL_BASE + 4'(n),
                                                   byte_total[REPORT_ORDER[n]],
                                                   '0, '0, 1'b0, 1'b0));
                    for (int n = 0; n < 6; n++)
                        outs.push_back(make_record(mafp_pkg::REC_UNIQUE_BASE + 4'(n),
                                                   unique_total[REPORT_ORDER[n]],
                                                   '0, '0, 1'b0,
                                                   set_overflow[REPORT_ORDER[n]]));
                    tracing = 1'b0;
                    clear_profile();
                end
            mafp_pkg::CMD_ABORT:
            begin
                tracing = 1'b0;
                clear_profile();
            end
            default: ;
        endcase
        for (int n = 0; n < outs.size(); n++)
        begin
            if (n == outs.size() - 1)
                outs[n].last = 1'b1;
            expected_records.push_back(outs[n]);
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_addr();
        return ($urandom_range(0, 1) == 0) ? addr_pool[$urandom_range(0, 15)] : rand64();
    endfunction

    function automatic logic [15:0] pick_bytes();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_op(mafp_pkg::cmd_t c, logic vk, logic [15:0] b,
                                     logic [63:0] a, logic [63:0] p);
        mafp_pkg::op_t op;
        op.cmd   = c;
        op.vkind = vk;
        op.bytes = b;
        op.addr  = a;
        op.pc    = p;
        pending_ops.push_back(op);
    endfunction

    function automatic void queue_session(int n);
        int k;
        int i;
        queue_op(mafp_pkg::CMD_BEGIN, $urandom_range(0, 1), pick_bytes(), rand64(), rand64());
        i = 0;
        while (i < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    queue_op(mafp_pkg::CMD_VBEGIN, $urandom_range(0, 1), pick_bytes(),
                             rand64(), rand64());
                    k = $urandom_range(0, 4);
                    for (int j = 0; j < k; j++)
                        queue_op(mafp_pkg::CMD_VACC, $urandom_range(0, 1), pick_bytes(),
                                 pick_addr(), rand64());
                    case ($urandom_range(0, 5))
                        0:       queue_op(mafp_pkg::CMD_VFAULT, $urandom_range(0, 1),
                                          pick_bytes(), rand64(), rand64());
                        1:       ;
                        default: queue_op(mafp_pkg::CMD_VEND, $urandom_range(0, 1),
                                          pick_bytes(), rand64(), rand64());
                    endcase
                    i += k + 2;
                end
                4, 5:
                begin
                    queue_op($urandom_range(0, 1) ? mafp_pkg::CMD_MST : mafp_pkg::CMD_MLD,
                             $urandom_range(0, 1), pick_bytes(), pick_addr(), rand64());
                    i++;
                end
                6, 7, 8:
                begin
                    queue_op($urandom_range(0, 1) ? mafp_pkg::CMD_SST : mafp_pkg::CMD_SLD,
                             $urandom_range(0, 1), pick_bytes(), pick_addr(), rand64());
                    i++;
                end
                default:
                begin
                    queue_op(mafp_pkg::cmd_t'($urandom_range(0, 15)), $urandom_range(0, 1),
                             pick_bytes(), pick_addr(), rand64());
                    i++;
                end
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            queue_op(mafp_pkg::CMD_ABORT, $urandom_range(0, 1), pick_bytes(), rand64(),
                     rand64());
        else
            queue_op(mafp_pkg::CMD_END, $urandom_range(0, 1), pick_bytes(), rand64(),
                     rand64());
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            beat_taken <= item.valid && item.ready;
            if (item.valid && item.ready)
                predict_records(mafp_pkg::op_t'({item.command, item.vector_kind,
                                                 item.access_bytes, item.access_address,
                                                 item.instr_pc}));
            if (result.valid && result.ready)
            begin
                if (expected_records.size() == 0)
                begin
                    $display("%0t: unexpected record kind=%0d bytes=%h", $time,
                             result.record_kind, result.byte_count);
                    fail_count <= fail_count + 1;
                end
                else if ({result.record_kind, result.byte_count, result.record_pc,
                          result.record_address, result.partial_flag, result.table_overflow,
                          result.last_record} != expected_records[0])
                begin
                    $display("%0t: mismatch expected kind=%0d bytes=%h pc=%h addr=%h part=%b ovf=%b last=%b",
                             $time, expected_records[0].kind, expected_records[0].bytes,
                             expected_records[0].pc, expected_records[0].addr,
                             expected_records[0].partial, expected_records[0].ovf,
                             expected_records[0].last);
                    $display("%0t: mismatch actual   kind=%0d bytes=%h pc=%h addr=%h part=%b ovf=%b last=%b",
                             $time, result.record_kind, result.byte_count, result.record_pc,
                             result.record_address, result.partial_flag,
                             result.table_overflow, result.last_record);
                    fail_count <= fail_count + 1;
                    void'(expected_records.pop_front());
                end
                else
                    void'(expected_records.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        mafp_pkg::op_t next_op;
        bit            drive_valid;
        bit            calm;
        if (rst_n)
        begin
            calm = pending_ops.size() < CALM_ITEMS;
            if (!item.valid || beat_taken)
            begin
                drive_valid = 1'b0;
                if (send_idle > 0)
                    send_idle--;
                else if (!calm && $urandom_range(0, 7) == 0)
                    send_idle = $urandom_range(0, 8);
                else if (pending_ops.size() != 0)
                begin
                    next_op = pending_ops.pop_front();
                    drive_valid = 1'b1;
                    item.command        <= next_op.cmd;
                    item.vector_kind    <= next_op.vkind;
                    item.access_bytes   <= next_op.bytes;
                    item.access_address <= next_op.addr;
                    item.instr_pc       <= next_op.pc;
                end
                item.valid <= drive_valid;
            end
            if (recv_idle > 0)
            begin
                recv_idle--;
                result.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                recv_idle = $urandom_range(0, 8);
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        item.valid          = 1'b0;
        item.command        = '0;
        item.vector_kind    = 1'b0;
        item.access_bytes   = '0;
        item.access_address = '0;
        item.instr_pc       = '0;
        result.ready        = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        beat_taken  = 1'b0;
        send_idle   = 0;
        recv_idle   = 0;
        tracing     = 1'b0;
        clear_profile();
        for (int i = 0; i < 16; i++)
            addr_pool[i] = rand64();
        addr_pool[0] = '0;
        addr_pool[1] = '1;

        queue_op(mafp_pkg::CMD_SLD, 1'b0, 16'h10, 64'h100, '0);
        queue_op(mafp_pkg::CMD_VBEGIN, 1'b1, 16'h0, '0, 64'h44);
        queue_op(mafp_pkg::CMD_END, 1'b0, '0, '0, '0);
        queue_op(mafp_pkg::CMD_BEGIN, 1'b0, '0, '0, '0);
        queue_op(mafp_pkg::CMD_SLD, 1'b0, 16'h0, 64'h0, '0);
        queue_op(mafp_pkg::CMD_SST, 1'b1, 16'hffff, '1, '1);
        queue_op(mafp_pkg::CMD_SST, 1'b0, 16'h0001, '1, '0);
        queue_op(mafp_pkg::CMD_MLD, 1'b0, 16'h8, 64'h0, '1);
        queue_op(mafp_pkg::CMD_MST, 1'b1, 16'hffff, '1, '0);
        queue_op(mafp_pkg::CMD_VACC, 1'b0, 16'h20, 64'h500, '0);
        queue_op(mafp_pkg::CMD_VEND, 1'b0, '0, '0, '0);
        queue_op(mafp_pkg::CMD_VFAULT, 1'b0, '0, '0, '0);
        queue_op(mafp_pkg::CMD_VBEGIN, 1'b0, '0, '0, 64'h1000);
        queue_op(mafp_pkg::CMD_VACC, 1'b0, 16'h0, 64'h900, '0);
        queue_op(mafp_pkg::CMD_VACC, 1'b0, 16'hffff, 64'h940, '0);
        queue_op(mafp_pkg::CMD_VACC, 1'b0, 16'h40, 64'h980, '0);
        queue_op(mafp_pkg::CMD_VEND, 1'b0, '0, '0, '0);
        queue_op(mafp_pkg::CMD_VBEGIN, 1'b1, '0, '0, '1);
        queue_op(mafp_pkg::CMD_VBEGIN, 1'b1, '0, '0, 64'h2000);
        queue_op(mafp_pkg::CMD_VACC, 1'b0, 16'h10, 64'h940, '0);
        queue_op(mafp_pkg::CMD_VFAULT, 1'b0, '0, '0, '0);
        queue_op(mafp_pkg::cmd_t'(4'd11), 1'b1, 16'hffff, '1, '1);
        queue_op(mafp_pkg::cmd_t'(4'd15), 1'b1, 16'hffff, '1, '1);
        queue_op(mafp_pkg::CMD_VBEGIN, 1'b0, '0, '0, 64'h3000);
        queue_op(mafp_pkg::CMD_END, 1'b0, '0, '0, '0);

        queue_op(mafp_pkg::CMD_BEGIN, 1'b0, '0, '0, '0);
        for (int i = 0; i < 40; i++)
            queue_op(mafp_pkg::CMD_SLD, 1'b0, 16'h4, rand64(), '0);
        queue_op(mafp_pkg::CMD_SLD, 1'b0, 16'h4, addr_pool[2], '0);
        queue_op(mafp_pkg::CMD_MLD, 1'b0, 16'h4, addr_pool[2], 64'h77);
        queue_op(mafp_pkg::CMD_BEGIN, 1'b0, '0, '0, '0);
        queue_op(mafp_pkg::CMD_SLD, 1'b0, 16'h4, addr_pool[3], '0);
        queue_op(mafp_pkg::CMD_END, 1'b0, '0, '0, '0);

        for (int total = 0; total < 300; )
        begin
            int n;
            n = $urandom_range(10, 40);
            queue_session(n);
            total += n + 2;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || item.valid)
            @(posedge clk);
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (QUIET_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
